>>> hdl/pbtw_pkg.sv
`default_nettype none

package pbtw_pkg;

	// Palette size and screen geometry.
	localparam int PALETTE_DEPTH = 256;
	localparam int SCREEN_HEIGHT = 192;

	// Derived widths: entry index and entry count (count can reach the depth itself).
	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	// Field widths of the words on both channels.
	localparam int COLOR_W = 16;
	localparam int INDEX_W = 8;
	localparam int ADDR_W  = 15;
	localparam int POS_W   = 16;

	// Raster position of the last pixel of the screen (256 pixels per line).
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(256 * SCREEN_HEIGHT - 1);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

	// Halfword address in the 8x8-tile, 8 bpp layout: tile row, tile column,
	// line within the tile, pixel pair within the line.
	function automatic logic [ADDR_W-1:0] tile_addr(input logic [POS_W-1:0] pos);
		logic [7:0] x;
		logic [7:0] y;
		x = pos[7:0];
		y = pos[15:8];
		return {y[7:3], x[7:3], y[2:0], x[2:1]};
	endfunction

endpackage

`default_nettype wire

>>> hdl/palette_builder_tiled_writer_unit.sv
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------------------
// input   | in        | in_valid/in_ready  | pixel_color, frame_start
// output  | out       | out_valid/out_ready| color_index, new_entry, palette_overflow,
//         |           |                    | tile_address, upper_byte
//
// From acceptance until its result is in the output register, a word is compared with the
// filled entries in order from entry 0 and stops at the first hit or after the last entry:
// one comparator checks one palette entry per cycle against the registered read port.
// The block accepts a new word once the previous result has moved to the output
// register, even while that result still waits for out_ready.
// Reset clears the sequencer, the entry count, the position and the output valid;
// the palette memory is not cleared, since only entries below the count are read.
`default_nettype none

module palette_builder_tiled_writer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [pbtw_pkg::COLOR_W-1:0]  pixel_color,
	input  wire logic                          frame_start,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [pbtw_pkg::INDEX_W-1:0]       color_index,
	output logic                               new_entry,
	output logic                               palette_overflow,
	output logic [pbtw_pkg::ADDR_W-1:0]        tile_address,
	output logic                               upper_byte
);

	pbtw_pkg::state_t state_q;

	logic [pbtw_pkg::COLOR_W-1:0] color_q;
	logic [pbtw_pkg::CNT_W-1:0]   count_q;
	logic [pbtw_pkg::POS_W-1:0]   pos_q;
	logic [pbtw_pkg::ADDR_W-1:0]  addr_q;
	logic                         upper_q;
	logic [pbtw_pkg::CNT_W-1:0]   rd_idx_q;

	// Read stage of the search.
	logic                         cmp_vld_s1;
	logic [pbtw_pkg::IDX_W-1:0]   cmp_idx_s1;
	logic [pbtw_pkg::COLOR_W-1:0] rd_data_s1;

	// Result of the finished search.
	logic [pbtw_pkg::INDEX_W-1:0] res_index_q;
	logic                         res_new_q;
	logic                         res_ovf_q;

	logic out_valid_q;

	logic [pbtw_pkg::COLOR_W-1:0] palette_mem [pbtw_pkg::PALETTE_DEPTH];

	logic in_acc;
	logic hit;
	logic miss;
	logic room;
	logic rd_en;
	logic wr_en;
	logic out_load;
	logic [pbtw_pkg::POS_W-1:0] pos_eff;

	// Handshake and search decisions.
	assign in_ready = (state_q == pbtw_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign pos_eff  = frame_start ? '0 : pos_q;
	assign hit      = (state_q == pbtw_pkg::ST_SEARCH) && cmp_vld_s1 && (rd_data_s1 == color_q);
	assign miss     = (state_q == pbtw_pkg::ST_SEARCH) && !hit && (rd_idx_q == count_q);
	assign room     = (count_q < pbtw_pkg::CNT_W'(pbtw_pkg::PALETTE_DEPTH));
	assign rd_en    = (state_q == pbtw_pkg::ST_SEARCH) && !hit && (rd_idx_q < count_q);
	assign wr_en    = miss && room;
	assign out_load = (state_q == pbtw_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// Palette memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			palette_mem[count_q[pbtw_pkg::IDX_W-1:0]] <= color_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= palette_mem[rd_idx_q[pbtw_pkg::IDX_W-1:0]];
			cmp_idx_s1 <= rd_idx_q[pbtw_pkg::IDX_W-1:0];
		end
	end

	// Sequencer, counters and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbtw_pkg::ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				pbtw_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (frame_start) begin
							count_q <= '0;
						end
						pos_q      <= (pos_eff >= pbtw_pkg::LAST_POS) ? '0 : pos_eff + 1'b1;
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= pbtw_pkg::ST_SEARCH;
					end
				end
				pbtw_pkg::ST_SEARCH: begin
					cmp_vld_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (wr_en) begin
						count_q <= count_q + 1'b1;
					end
					if (hit || miss) begin
						state_q <= pbtw_pkg::ST_DONE;
					end
				end
				pbtw_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= pbtw_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pbtw_pkg::ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latched input word and address of the pixel.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			color_q <= pixel_color;
			addr_q  <= pbtw_pkg::tile_addr(pos_eff);
			upper_q <= pos_eff[0];
		end
	end

	// Search result.
	always_ff @(posedge clk) begin
		if (hit) begin
			res_index_q <= pbtw_pkg::INDEX_W'(cmp_idx_s1);
			res_new_q   <= 1'b0;
			res_ovf_q   <= 1'b0;
		end else if (miss) begin
			res_index_q <= room ? pbtw_pkg::INDEX_W'(count_q) : '0;
			res_new_q   <= room;
			res_ovf_q   <= !room;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			color_index      <= res_index_q;
			new_entry        <= res_new_q;
			palette_overflow <= res_ovf_q;
			tile_address     <= addr_q;
			upper_byte       <= upper_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	// The entry count never exceeds the palette depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pbtw_pkg::CNT_W'(pbtw_pkg::PALETTE_DEPTH))
		else $error("entry count beyond palette depth");

	// The read pointer never runs past the filled entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pbtw_pkg::ST_SEARCH) |-> (rd_idx_q <= count_q))
		else $error("search read pointer beyond entry count");

	// An overflow result carries index zero and no new entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && palette_overflow) |-> (!new_entry && color_index == '0))
		else $error("overflow result with index or new entry");

	// The palette is written only when a search ends in a miss with room left.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (state_q == pbtw_pkg::ST_DONE && res_new_q))
		else $error("palette write without new entry result");
`endif

endmodule

`default_nettype wire

>>> verif/palette_builder_checker.sv
// Watches both channels of the palette builder, predicts every result word
// from its own copy of the palette and raster position, and compares.
module palette_builder_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [pbtw_pkg::COLOR_W-1:0]  pixel_color,
	input  wire logic                          frame_start,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [pbtw_pkg::INDEX_W-1:0]  color_index,
	input  wire logic                          new_entry,
	input  wire logic                          palette_overflow,
	input  wire logic [pbtw_pkg::ADDR_W-1:0]   tile_address,
	input  wire logic                          upper_byte,
	output int                                 fail_count,
	output int                                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [pbtw_pkg::INDEX_W-1:0] color_index;
		logic                         new_entry;
		logic                         palette_overflow;
		logic [pbtw_pkg::ADDR_W-1:0]  tile_address;
		logic                         upper_byte;
	} pixel_result_t;

	// Shadow copy of the block's state.
	logic [pbtw_pkg::COLOR_W-1:0] palette_shadow [pbtw_pkg::PALETTE_DEPTH];
	logic [pbtw_pkg::CNT_W-1:0]   entries_used;
	logic [pbtw_pkg::POS_W-1:0]   raster_pos;

	// Predicted words, oldest first.
	pixel_result_t pending_results [$];

	// Looks a color up in the shadow palette, appends it on a miss while room
	// remains, and works out the tiled address of the current raster position.
	task automatic map_pixel(input logic [pbtw_pkg::COLOR_W-1:0] color, input logic first,
			output pixel_result_t res);
		bit          hit;
		int unsigned idx;
		int unsigned x;
		int unsigned y;
		int unsigned addr;
		hit = 1'b0;
		idx = 0;
		res = '0;
		if (first) begin
			entries_used = '0;
			raster_pos = '0;
		end
		if (raster_pos > pbtw_pkg::LAST_POS) begin
			raster_pos = '0;
		end
		for (int i = 0; i < int'(entries_used) && !hit; i++) begin
			if (palette_shadow[i] == color) begin
				hit = 1'b1;
				idx = i;
			end
		end
		if (!hit) begin
			if (entries_used < pbtw_pkg::CNT_W'(pbtw_pkg::PALETTE_DEPTH)) begin
				idx = entries_used;
				palette_shadow[idx] = color;
				entries_used = entries_used + 1'b1;
				res.new_entry = 1'b1;
			end else begin
				idx = 0;
				res.palette_overflow = 1'b1;
			end
		end
		x = raster_pos[7:0];
		y = raster_pos[15:8];
		addr = (x >> 3) * 32 + ((x & 7) >> 1) + (y >> 3) * 1024 + ((y & 7) << 2);
		res.color_index = idx[pbtw_pkg::INDEX_W-1:0];
		res.tile_address = addr[pbtw_pkg::ADDR_W-1:0];
		res.upper_byte = x[0];
		if (raster_pos >= pbtw_pkg::LAST_POS) begin
			raster_pos = '0;
		end else begin
			raster_pos = raster_pos + 1'b1;
		end
	endtask

	// The output word is retired before a new input word is predicted; a word
	// accepted on this edge cannot have its result on the same edge.
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_word;
		pixel_result_t new_word;
		if (!arst_n) begin
			entries_used = '0;
			raster_pos = '0;
			pending_results.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected output word: index %0d address %0h",
						color_index, tile_address);
					fail_count++;
				end else begin
					exp_word = pending_results.pop_front();
					if (color_index !== exp_word.color_index) begin
						$error("color_index: expected %0d, got %0d",
							exp_word.color_index, color_index);
						fail_count++;
					end
					if (new_entry !== exp_word.new_entry) begin
						$error("new_entry: expected %0b, got %0b",
							exp_word.new_entry, new_entry);
						fail_count++;
					end
					if (palette_overflow !== exp_word.palette_overflow) begin
						$error("palette_overflow: expected %0b, got %0b",
							exp_word.palette_overflow, palette_overflow);
						fail_count++;
					end
					if (tile_address !== exp_word.tile_address) begin
						$error("tile_address: expected %0h, got %0h",
							exp_word.tile_address, tile_address);
						fail_count++;
					end
					if (upper_byte !== exp_word.upper_byte) begin
						$error("upper_byte: expected %0b, got %0b",
							exp_word.upper_byte, upper_byte);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				map_pixel(pixel_color, frame_start, new_word);
				pending_results.push_back(new_word);
			end
		end
		outstanding = pending_results.size();
	end

endmodule

>>> verif/tb_palette_builder_tiled_writer_unit.sv
// Stimulus and verdict for the palette builder; the checker does the prediction.
module tb_palette_builder_tiled_writer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [pbtw_pkg::COLOR_W-1:0] pixel_color;
	logic                         frame_start;
	logic                         out_valid;
	logic                         out_ready;
	logic [pbtw_pkg::INDEX_W-1:0] color_index;
	logic                         new_entry;
	logic                         palette_overflow;
	logic [pbtw_pkg::ADDR_W-1:0]  tile_address;
	logic                         upper_byte;
	int                           fail_count;
	int                           outstanding;

	// Idling percentages of the current phase.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	palette_builder_tiled_writer_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pixel_color      (pixel_color),
		.frame_start      (frame_start),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.color_index      (color_index),
		.new_entry        (new_entry),
		.palette_overflow (palette_overflow),
		.tile_address     (tile_address),
		.upper_byte       (upper_byte)
	);

	palette_builder_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pixel_color      (pixel_color),
		.frame_start      (frame_start),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.color_index      (color_index),
		.new_entry        (new_entry),
		.palette_overflow (palette_overflow),
		.tile_address     (tile_address),
		.upper_byte       (upper_byte),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog for a hung block.
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	// The receiver stalls at random according to the phase.
	always @(negedge clk) begin
		if (recv_stall_pct == 0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one word, after optional idle cycles, and returns at the falling
	// edge after it has been accepted. Valid stays high for a following word.
	task automatic send_pixel(input logic [pbtw_pkg::COLOR_W-1:0] color, input logic first);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_color <= color;
		frame_start <= first;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Odd multiplier: distinct steps give distinct colors.
	function automatic logic [pbtw_pkg::COLOR_W-1:0] spread_color(
			input logic [pbtw_pkg::COLOR_W-1:0] base, input int unsigned step);
		return pbtw_pkg::COLOR_W'(base + step * 40503);
	endfunction

	// Fills the whole palette with distinct colors, then mixes hits with misses
	// against the full palette.
	task automatic fill_and_overflow();
		logic [pbtw_pkg::COLOR_W-1:0] base;
		int unsigned                  kind;
		base = pbtw_pkg::COLOR_W'($urandom);
		for (int i = 0; i < pbtw_pkg::PALETTE_DEPTH; i++) begin
			send_pixel(spread_color(base, i), i == 0);
		end
		for (int j = 0; j < 48; j++) begin
			kind = $urandom_range(3);
			if (kind == 0) begin
				send_pixel(spread_color(base, $urandom_range(pbtw_pkg::PALETTE_DEPTH - 1)),
					1'b0);
			end else if (kind == 1) begin
				send_pixel(spread_color(base, (j & 1) ? pbtw_pkg::PALETTE_DEPTH - 1 : 0),
					1'b0);
			end else begin
				send_pixel(spread_color(base, $urandom_range(60000, pbtw_pkg::PALETTE_DEPTH)),
					1'b0);
			end
		end
	endtask

	// Frames drawn from small color pools, with noise colors, frames that
	// begin without a frame start and frame starts in the middle of a frame.
	task automatic random_frames(input int unsigned count);
		logic [pbtw_pkg::COLOR_W-1:0] pool [128];
		logic [pbtw_pkg::COLOR_W-1:0] color;
		logic                         first;
		int unsigned                  pool_n;
		int unsigned                  frame_len;
		int unsigned                  sent;
		int unsigned                  pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				pool_n = $urandom_range(8, 1);
			end else if (pick < 90) begin
				pool_n = $urandom_range(40, 9);
			end else begin
				pool_n = $urandom_range(120, 41);
			end
			for (int i = 0; i < pool_n; i++) begin
				pool[i] = pbtw_pkg::COLOR_W'($urandom);
			end
			frame_len = $urandom_range(40, 1);
			for (int j = 0; j < frame_len && sent < count; j++) begin
				if ($urandom_range(99) < 85) begin
					color = pool[$urandom_range(pool_n - 1)];
				end else begin
					color = pbtw_pkg::COLOR_W'($urandom);
				end
				first = (j == 0 && $urandom_range(99) < 85) || ($urandom_range(99) < 3);
				send_pixel(color, first);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel_color = '0;
		frame_start = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty palette, extreme colors, hits, repeated and back to
		// back frame starts, a start on a color already stored.
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h8000, 1'b0);
		send_pixel(16'h7FFF, 1'b0);
		send_pixel(16'h5555, 1'b0);
		send_pixel(16'hAAAA, 1'b0);
		send_pixel(16'hAAAA, 1'b0);
		send_pixel(16'h5555, 1'b0);
		send_pixel(16'h7FFF, 1'b0);
		send_pixel(16'hAAAA, 1'b1);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hAAAA, 1'b0);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'h0001, 1'b0);
		send_pixel(16'hFF00, 1'b0);
		send_pixel(16'h00FF, 1'b0);
		send_pixel(16'h0001, 1'b0);

		// Full palette and overflow.
		fill_and_overflow();

		// Random frames under each idling pattern.
		random_frames(45);
		send_idle_pct = 50;
		random_frames(45);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		random_frames(45);
		send_idle_pct = 16;
		recv_stall_pct = 16;
		random_frames(45);

		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (pbtw_pkg::PALETTE_DEPTH + 40) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
